/* rtl/core/utn_pkg.sv */
package utn_pkg;

	localparam int WORD_DEPTH = 32;
	localparam int CNT_W = $clog2(WORD_DEPTH + 1);
	localparam int ADDR_W = $clog2(WORD_DEPTH > 1 ? WORD_DEPTH : 2);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WORD_DEPTH);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_LBRK   = 8'h5b;
	localparam logic [7:0] CH_RBRK   = 8'h5d;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_QUEST  = 8'h3f;
	localparam logic [7:0] CH_EXCL   = 8'h21;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DASH   = 8'h2d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7a;
	localparam logic [7:0] CASE_GAP  = 8'h20;

	// Microcode step addresses.
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] P_IDLE    = PC_W'(0);
	localparam logic [PC_W-1:0] P_PICK    = PC_W'(1);
	localparam logic [PC_W-1:0] P_LA      = PC_W'(2);
	localparam logic [PC_W-1:0] P_AFTER   = PC_W'(3);
	localparam logic [PC_W-1:0] P_EOL     = PC_W'(4);
	localparam logic [PC_W-1:0] P_STORE   = PC_W'(5);
	localparam logic [PC_W-1:0] P_HANDLE  = PC_W'(6);
	localparam logic [PC_W-1:0] P_PUT     = PC_W'(7);
	localparam logic [PC_W-1:0] P_FL_HS   = PC_W'(8);
	localparam logic [PC_W-1:0] P_FL_RD   = PC_W'(9);
	localparam logic [PC_W-1:0] P_FL_EM   = PC_W'(10);
	localparam logic [PC_W-1:0] P_POSTFL  = PC_W'(11);
	localparam logic [PC_W-1:0] P_CHK_WS  = PC_W'(12);
	localparam logic [PC_W-1:0] P_SET_HS  = PC_W'(13);
	localparam logic [PC_W-1:0] P_WRITE   = PC_W'(14);
	localparam logic [PC_W-1:0] P_RET     = PC_W'(15);
	localparam logic [PC_W-1:0] P_EOLFL   = PC_W'(16);
	localparam logic [PC_W-1:0] P_FIN     = PC_W'(17);
	localparam logic [PC_W-1:0] P_END     = PC_W'(18);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_LOAD_LA,
		OP_LOAD_CUR,
		OP_STORE_LA,
		OP_HANDLE,
		OP_EMIT_HS,
		OP_EMIT_WORD,
		OP_CLEAR,
		OP_SET_HS,
		OP_WRITE,
		OP_SET_FINAL,
		OP_FINISH,
		OP_END_RUN
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_NO_LA,
		C_NOT_EOL,
		C_NOT_PUT,
		C_NO_FLUSH,
		C_RD_DONE,
		C_FINAL,
		C_P_NOT_WS,
		C_PASS_LA
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// The control program. A step jumps to its target when its condition
	// holds and otherwise falls through to the next step.
	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		unique case (pc)
			P_IDLE:   w = '{OP_ACCEPT,    C_NO_INPUT, P_IDLE};
			P_PICK:   w = '{OP_NONE,      C_NO_LA,    P_AFTER};
			P_LA:     w = '{OP_LOAD_LA,   C_ALWAYS,   P_HANDLE};
			P_AFTER:  w = '{OP_NONE,      C_NOT_EOL,  P_STORE};
			P_EOL:    w = '{OP_LOAD_CUR,  C_ALWAYS,   P_HANDLE};
			P_STORE:  w = '{OP_STORE_LA,  C_ALWAYS,   P_END};
			P_HANDLE: w = '{OP_HANDLE,    C_NOT_PUT,  P_RET};
			P_PUT:    w = '{OP_NONE,      C_NO_FLUSH, P_WRITE};
			P_FL_HS:  w = '{OP_EMIT_HS,   C_NEVER,    P_IDLE};
			P_FL_RD:  w = '{OP_NONE,      C_RD_DONE,  P_POSTFL};
			P_FL_EM:  w = '{OP_EMIT_WORD, C_ALWAYS,   P_FL_RD};
			P_POSTFL: w = '{OP_CLEAR,     C_FINAL,    P_FIN};
			P_CHK_WS: w = '{OP_NONE,      C_P_NOT_WS, P_WRITE};
			P_SET_HS: w = '{OP_SET_HS,    C_ALWAYS,   P_RET};
			P_WRITE:  w = '{OP_WRITE,     C_NEVER,    P_IDLE};
			P_RET:    w = '{OP_NONE,      C_PASS_LA,  P_AFTER};
			P_EOLFL:  w = '{OP_SET_FINAL, C_ALWAYS,   P_FL_HS};
			P_FIN:    w = '{OP_FINISH,    C_NEVER,    P_IDLE};
			P_END:    w = '{OP_END_RUN,   C_ALWAYS,   P_IDLE};
			default:  w = '{OP_NONE,      C_ALWAYS,   P_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/utn_ram.sv */
module utn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* rtl/core/utterance_text_normalizer.sv */
// Text line normaliser: takes one byte of a line per input word and returns
// the normalised bytes as output words. Brackets, colon, semicolon, question
// and exclamation marks, newline and zero bytes are dropped; comma and
// backslash become a space; text from one '#' to the next (or to the end of
// the line) is skipped; a..z are upper-cased; a '-' followed by whitespace
// discards the partial word and leaves a held space. Output is held back by
// one byte of lookahead, the last whitespace and a word store of WORD_DEPTH
// bytes, so an input word may cause no output word or a burst of them; the
// last word of each burst has last_of_run set and the last word of a line
// has line_done set, with char_valid low if the line produced nothing.
// The block handles one input word at a time under a small microcoded
// sequencer that runs one control step per cycle unless the output side
// stalls it; each byte flushed from the word store takes a read step and
// an emit step because the single-port store has a registered read port.
// The sequencer holds its step while the output side is stalled and waits in its idle step until an input word arrives.
module utterance_text_normalizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       last_of_run,
	output logic       line_done
);

	import utn_pkg::*;

	ctl_t ctl;
	logic [PC_W-1:0] pc_q, pc_d;
	logic            take;
	logic            stall;

	logic [7:0]       cur_char_q;
	logic             eol_q;
	logic [7:0]       la_byte_q;
	logic             la_valid_q;
	logic             in_comment_q;
	logic [7:0]       hs_byte_q;
	logic             hs_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [7:0]       byte_q;
	logic [7:0]       nxt_q;
	logic [7:0]       p_q;
	logic             pass_q;
	logic             final_q;
	logic             any_q;

	logic [7:0] hold_char_q;
	logic       hold_cv_q;
	logic       hold_v_q;
	logic [7:0] out_char_q;
	logic       out_cv_q;
	logic       out_last_q;
	logic       out_done_q;
	logic       out_valid_q;

	logic       in_fire;
	logic       out_free;
	logic       emit_req;
	logic [7:0] emit_char;
	logic       emit_cv;
	logic       end_req;

	logic       cls_put;
	logic [7:0] cls_char;
	logic       cls_close;
	logic       cls_open;
	logic       cls_del;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]        ram_rdata;

	assign ctl       = ucode(pc_q);
	assign in_ready  = (pc_q == P_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Decode of the byte under handling.
	always_comb begin
		cls_put   = 1'b0;
		cls_char  = byte_q;
		cls_close = 1'b0;
		cls_open  = 1'b0;
		cls_del   = 1'b0;
		if (in_comment_q) begin
			cls_close = (byte_q == CH_HASH);
		end else if (byte_q == CH_NUL || byte_q == CH_LPAR || byte_q == CH_RPAR ||
				byte_q == CH_LBRK || byte_q == CH_RBRK || byte_q == CH_COLON ||
				byte_q == CH_SEMI || byte_q == CH_QUEST || byte_q == CH_EXCL ||
				byte_q == CH_LF) begin
			cls_put = 1'b0;
		end else if (byte_q == CH_COMMA || byte_q == CH_BSLASH) begin
			cls_put  = 1'b1;
			cls_char = CH_SPACE;
		end else if (byte_q == CH_HASH) begin
			cls_open = 1'b1;
		end else if (byte_q == CH_DASH) begin
			cls_del = is_ws(nxt_q);
			cls_put = !is_ws(nxt_q);
		end else begin
			cls_put = 1'b1;
			if (byte_q >= CH_LOW_A && byte_q <= CH_LOW_Z) begin
				cls_char = byte_q - CASE_GAP;
			end
		end
	end

	always_comb begin
		emit_req  = 1'b0;
		emit_char = hs_byte_q;
		emit_cv   = 1'b1;
		end_req   = 1'b0;
		unique case (ctl.op)
			OP_EMIT_HS: begin
				emit_req = hs_valid_q;
			end
			OP_EMIT_WORD: begin
				emit_req  = 1'b1;
				emit_char = ram_rdata;
			end
			OP_FINISH: begin
				emit_req  = !any_q;
				emit_char = CH_NUL;
				emit_cv   = 1'b0;
			end
			OP_END_RUN: begin
				end_req = hold_v_q;
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
		// A new result pushes the held one to the output register.
		stall = (emit_req && hold_v_q && !out_free) || (end_req && !out_free);
	end

	always_comb begin
		unique case (ctl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_INPUT: take = !in_valid;
			C_NO_LA:    take = !la_valid_q;
			C_NOT_EOL:  take = !eol_q;
			C_NOT_PUT:  take = !cls_put;
			C_NO_FLUSH: take = !is_ws(p_q) && (count_q < DEPTH_C);
			C_RD_DONE:  take = (rd_idx_q >= count_q);
			C_FINAL:    take = final_q;
			C_P_NOT_WS: take = !is_ws(p_q);
			C_PASS_LA:  take = !pass_q;
			default:    take = 1'b1;
		endcase
		if (stall) begin
			pc_d = pc_q;
		end else if (take) begin
			pc_d = ctl.target;
		end else begin
			pc_d = pc_q + PC_W'(1);
		end
	end

	assign ram_we   = (ctl.op == OP_WRITE) && !stall;
	assign ram_addr = (ctl.op == OP_WRITE) ? count_q[ADDR_W-1:0] : rd_idx_q[ADDR_W-1:0];

	utn_ram #(
		.WIDTH(8),
		.DEPTH(WORD_DEPTH)
	) u_word_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(p_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= P_IDLE;
			la_valid_q   <= 1'b0;
			in_comment_q <= 1'b0;
			hs_valid_q   <= 1'b0;
			count_q      <= '0;
			pass_q       <= 1'b0;
			final_q      <= 1'b0;
			any_q        <= 1'b0;
			hold_v_q     <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (!stall) begin
				unique case (ctl.op)
					OP_ACCEPT: begin
						if (in_fire) begin
							any_q <= 1'b0;
						end
					end
					OP_LOAD_LA: begin
						la_valid_q <= 1'b0;
						pass_q     <= 1'b0;
					end
					OP_LOAD_CUR: begin
						pass_q <= 1'b1;
					end
					OP_STORE_LA: begin
						la_valid_q <= 1'b1;
					end
					OP_HANDLE: begin
						if (cls_close) begin
							in_comment_q <= 1'b0;
						end
						if (cls_open) begin
							in_comment_q <= 1'b1;
						end
						if (cls_del) begin
							count_q    <= '0;
							hs_valid_q <= 1'b1;
						end
					end
					OP_EMIT_WORD: begin
						count_q <= count_q;
					end
					OP_CLEAR: begin
						hs_valid_q <= 1'b0;
						count_q    <= '0;
					end
					OP_SET_HS: begin
						hs_valid_q <= 1'b1;
					end
					OP_WRITE: begin
						count_q <= count_q + CNT_W'(1);
					end
					OP_SET_FINAL: begin
						final_q <= 1'b1;
					end
					OP_FINISH: begin
						in_comment_q <= 1'b0;
						final_q      <= 1'b0;
					end
					default: begin
						pass_q <= pass_q;
					end
				endcase
				if (emit_req) begin
					hold_v_q <= 1'b1;
					any_q    <= 1'b1;
				end else if (end_req) begin
					hold_v_q <= 1'b0;
				end
			end
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (!stall) begin
			unique case (ctl.op)
				OP_ACCEPT: begin
					if (in_fire) begin
						cur_char_q <= in_char;
						eol_q      <= end_of_line;
					end
				end
				OP_LOAD_LA: begin
					byte_q <= la_byte_q;
					nxt_q  <= cur_char_q;
				end
				OP_LOAD_CUR: begin
					byte_q <= cur_char_q;
					nxt_q  <= CH_NUL;
				end
				OP_STORE_LA: begin
					la_byte_q <= cur_char_q;
				end
				OP_HANDLE: begin
					p_q <= cls_char;
					if (cls_del) begin
						hs_byte_q <= CH_SPACE;
					end
				end
				OP_EMIT_HS: begin
					rd_idx_q <= '0;
				end
				OP_EMIT_WORD: begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				OP_SET_HS: begin
					hs_byte_q <= p_q;
				end
				default: begin
					p_q <= p_q;
				end
			endcase
			if (emit_req) begin
				hold_char_q <= emit_char;
				hold_cv_q   <= emit_cv;
			end
		end
	end

	// Output register: the held result moves here once the next result or
	// the end of the run shows whether it is the last of its burst.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall && ((emit_req && hold_v_q) || end_req)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && ((emit_req && hold_v_q) || end_req)) begin
			out_char_q <= hold_char_q;
			out_cv_q   <= hold_cv_q;
			out_last_q <= end_req;
			out_done_q <= end_req && eol_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign char_valid  = out_cv_q;
	assign last_of_run = out_last_q;
	assign line_done   = out_done_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("word count beyond store depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (count_q < DEPTH_C))
		else $error("write into a full word store");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !hold_v_q)
		else $error("new word taken with a result still held");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_done) |-> last_of_run)
		else $error("end of line without end of burst");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !char_valid) |-> (line_done && out_char == CH_NUL))
		else $error("empty result outside the end of a line");

endmodule

/* tb/sv/tb_utterance_text_normalizer.sv */
`timescale 1ns / 1ps

module tb_utterance_text_normalizer;
	import utn_pkg::*;

	localparam logic [7:0] CH_VT = 8'h0b;
	localparam logic [7:0] CH_FF = 8'h0c;
	localparam int HOLD_CYCLES = 400;
	// Worst case is about 190 bytes each releasing 35 words under heavy stalls;
	// the limit leaves a wide margin over the time that such traffic takes to
	// drain through the block.
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
	} raw_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       vld;
		logic       run_end;
		logic       line_end;
	} norm_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_char = 8'h00;
	logic       end_of_line = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       char_valid;
	logic       last_of_run;
	logic       line_done;

	utterance_text_normalizer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_char     (in_char),
		.end_of_line (end_of_line),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.char_valid  (char_valid),
		.last_of_run (last_of_run),
		.line_done   (line_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	raw_byte_t  line_bytes[$];
	logic [7:0] line_buf[$];
	norm_word_t due_words[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_go = 1'b0;
	int hold_left;
	int n_cycles = 0;
	int n_err = 0;
	int n_checked = 0;
	int n_bytes = 0;
	int n_lines = 0;
	int n_overflow = 0;
	int n_empty = 0;

	// Predictor state.
	logic [7:0] la_byte = 8'h00;
	bit         la_vld = 1'b0;
	bit         cmt = 1'b0;
	logic [7:0] gap_byte = 8'h00;
	bit         gap_vld = 1'b0;
	logic [7:0] word_buf [WORD_DEPTH];
	int         word_len = 0;

	function automatic bit is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic emit_char(input logic [7:0] c, input bit v);
		norm_word_t w;
		w.ch = c;
		w.vld = v;
		w.run_end = 1'b0;
		w.line_end = 1'b0;
		due_words.push_back(w);
	endtask

	task automatic flush_word();
		int i;
		if (gap_vld)
			emit_char(gap_byte, 1'b1);
		for (i = 0; i < word_len; i++)
			emit_char(word_buf[i], 1'b1);
		gap_vld = 1'b0;
		word_len = 0;
	endtask

	task automatic place_char(input logic [7:0] c);
		if (is_blank(c)) begin
			flush_word();
			gap_byte = c;
			gap_vld = 1'b1;
		end else begin
			if (word_len >= WORD_DEPTH) begin
				flush_word();
				n_overflow++;
			end
			word_buf[word_len] = c;
			word_len++;
		end
	endtask

	task automatic classify_byte(input logic [7:0] c, input logic [7:0] nxt);
		logic [7:0] u;
		if (cmt) begin
			if (c == CH_HASH)
				cmt = 1'b0;
		end else begin
			case (c)
				CH_NUL, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_COLON, CH_SEMI,
				CH_QUEST, CH_EXCL, CH_LF: ;
				CH_COMMA, CH_BSLASH: place_char(CH_SPACE);
				CH_HASH: cmt = 1'b1;
				CH_DASH: begin
					// A dash before whitespace throws away the partial word.
					if (is_blank(nxt)) begin
						word_len = 0;
						gap_byte = CH_SPACE;
						gap_vld = 1'b1;
					end else begin
						place_char(CH_DASH);
					end
				end
				default: begin
					u = c;
					if (c >= CH_LOW_A && c <= CH_LOW_Z)
						u = c - CASE_GAP;
					place_char(u);
				end
			endcase
		end
	endtask

	task automatic predict_normalized(input logic [7:0] c, input logic eol);
		int first;
		norm_word_t w;
		first = due_words.size();
		if (la_vld) begin
			la_vld = 1'b0;
			classify_byte(la_byte, c);
		end
		if (eol) begin
			classify_byte(c, CH_NUL);
			flush_word();
			if (due_words.size() == first) begin
				emit_char(CH_NUL, 1'b0);
				n_empty++;
			end
			w = due_words.pop_back();
			w.line_end = 1'b1;
			due_words.push_back(w);
			cmt = 1'b0;
			la_byte = CH_NUL;
			gap_byte = CH_NUL;
		end else begin
			la_byte = c;
			la_vld = 1'b1;
		end
		if (due_words.size() > first) begin
			w = due_words.pop_back();
			w.run_end = 1'b1;
			due_words.push_back(w);
		end
	endtask

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			n_err++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	// Stimulus helpers.
	task automatic push_byte(input logic [7:0] c, input logic eol);
		raw_byte_t r;
		r.ch = c;
		r.eol = eol;
		line_bytes.push_back(r);
	endtask

	task automatic push_text(input string s, input logic eol);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i], eol && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = CH_LOW_A + 8'($urandom_range(0, 25));
		if ($urandom_range(0, 1) == 1)
			c = c - CASE_GAP;
		return c;
	endfunction

	function automatic logic [7:0] rand_gap();
		case ($urandom_range(0, 10))
			6: return CH_TAB;
			7: return CH_VT;
			8: return CH_FF;
			9: return CH_CR;
			10: return CH_LF;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] rand_punct();
		case ($urandom_range(0, 10))
			0: return CH_LPAR;
			1: return CH_RPAR;
			2: return CH_LBRK;
			3: return CH_RBRK;
			4: return CH_COLON;
			5: return CH_SEMI;
			6: return CH_QUEST;
			7: return CH_EXCL;
			8: return CH_LF;
			9: return CH_COMMA;
			default: return CH_BSLASH;
		endcase
	endfunction

	task automatic add_letters(input int n);
		int i;
		for (i = 0; i < n; i++)
			line_buf.push_back(rand_letter());
	endtask

	// Builds one line of words, separators, deleting dashes, comments,
	// punctuation and noise, and queues it with the end mark on its last byte.
	task automatic queue_random_line(input bit with_long, output int len);
		int n_tok, k, kind, i;
		n_tok = $urandom_range(1, 5);
		for (k = 0; k < n_tok; k++) begin
			if (k != 0)
				line_buf.push_back(rand_gap());
			kind = $urandom_range(0, 99);
			if (with_long && k == 0) begin
				add_letters($urandom_range(33, 40));
			end else if (kind < 45) begin
				add_letters(($urandom_range(0, 19) == 0) ? $urandom_range(30, 38) :
					$urandom_range(1, 8));
			end else if (kind < 55) begin
				add_letters($urandom_range(1, 6));
				line_buf.push_back(CH_DASH);
				line_buf.push_back(rand_gap());
			end else if (kind < 63) begin
				line_buf.push_back(CH_HASH);
				add_letters($urandom_range(0, 4));
				if (k != n_tok - 1 || $urandom_range(0, 1) == 1)
					line_buf.push_back(CH_HASH);
			end else if (kind < 73) begin
				line_buf.push_back(rand_punct());
			end else if (kind < 81) begin
				add_letters($urandom_range(1, 4));
				line_buf.push_back(CH_DASH);
				add_letters($urandom_range(1, 4));
			end else begin
				line_buf.push_back(8'($urandom_range(1, 255)));
			end
		end
		len = line_buf.size();
		for (i = 0; i < len; i++)
			push_byte(line_buf[i], i == len - 1);
		line_buf.delete();
	endtask

	task automatic queue_random_lines(input int budget, input bit first_long);
		int cnt, len;
		cnt = 0;
		while (cnt < budget) begin
			queue_random_line(first_long && cnt == 0, len);
			cnt += len;
		end
	endtask

	task automatic drain();
		while (line_bytes.size() != 0 || in_valid || due_words.size() != 0)
			@(negedge clk);
	endtask

	// Input side: a word stays on the port, unchanged, until it is taken.
	always @(posedge clk or negedge arst_n) begin : driver
		raw_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_char <= 8'h00;
			end_of_line <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (line_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = line_bytes.pop_front();
				in_valid <= 1'b1;
				in_char <= nxt.ch;
				end_of_line <= nxt.eol;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : holdoff
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Predicts on every accepted input word, then checks any output word.
	always @(posedge clk) begin : monitor
		norm_word_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_normalized(in_char, end_of_line);
				n_bytes++;
				if (end_of_line)
					n_lines++;
			end
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					n_err++;
					$display("%0t: unexpected output word, expected none, got %h/%b/%b/%b",
						$time, out_char, char_valid, last_of_run, line_done);
				end else begin
					want = due_words.pop_front();
					n_checked++;
					check_field("out_char", want.ch, out_char);
					check_field("char_valid", want.vld, char_valid);
					check_field("last_of_run", want.run_end, last_of_run);
					check_field("line_done", want.line_end, line_done);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("tb_utterance_text_normalizer failed");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Comment closed by a hash with the next byte kept, comma as a space,
		// then a comment left open to the end of the line.
		push_text("#c#d,e#f", 1'b1);
		// Deleting dash at line start, backslash, a high byte, trailing dash.
		push_byte(CH_DASH, 1'b0);
		push_byte(CH_TAB, 1'b0);
		push_text("z\\", 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(CH_DASH, 1'b1);
		// Nothing but dropped bytes: the line ends with an empty word.
		push_text("()[]:;?!", 1'b0);
		push_byte(CH_LF, 1'b1);
		push_byte(8'h01, 1'b0);
		push_byte(CH_FF, 1'b0);
		push_byte(8'hff, 1'b1);
		push_byte(CH_SPACE, 1'b1);
		drain();

		// Long receiver hold while the sender keeps offering words.
		queue_random_lines(30, 1'b1);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		drain();

		send_idle_pct = 51;
		queue_random_lines(30, 1'b0);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 51;
		queue_random_lines(30, 1'b0);
		drain();

		send_idle_pct = 30;
		recv_stall_pct = 30;
		queue_random_lines(30, 1'b0);
		drain();

		repeat (50) @(negedge clk);
		$display("Sent %0d bytes in %0d lines; %0d output words checked.",
			n_bytes, n_lines, n_checked);
		$display("Word store overflowed %0d times; %0d lines came out empty.",
			n_overflow, n_empty);
		if (n_err == 0)
			$display("tb_utterance_text_normalizer passed");
		else
			$display("tb_utterance_text_normalizer failed");
		$finish;
	end

endmodule
